// ===== hw/rtl/bfa_pkg.sv =====
// Package with the word types and constants of the binary32 adder.
package bfa_pkg;

    localparam logic [23:0] HIDDEN_BIT = 24'h800000;
    localparam logic [22:0] FRAC_MASK  = 23'h7fffff;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_ZERO     = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [31:0] sum;
        logic [1:0]  status;
    } out_word_t;

endpackage

// ===== hw/rtl/bfa_lzc.sv =====
// Leading zero counter over a 25-bit significand, a four-level priority tree.
module bfa_lzc (
    input  logic [24:0] value,
    output logic [4:0]  count
);
    import bfa_pkg::*;

    logic [31:0] padded;
    logic [15:0] l1;
    logic [7:0]  l2;
    logic [3:0]  l3;
    logic [1:0]  l4;

    always_comb
    begin
        padded = {value, 7'h7f};
        count = 5'd0;
        l1 = padded[31:16];
        if (l1 == 16'h0)
        begin
            count[4] = 1'b1;
            l1 = padded[15:0];
        end
        l2 = l1[15:8];
        if (l2 == 8'h0)
        begin
            count[3] = 1'b1;
            l2 = l1[7:0];
        end
        l3 = l2[7:4];
        if (l3 == 4'h0)
        begin
            count[2] = 1'b1;
            l3 = l2[3:0];
        end
        l4 = l3[3:2];
        if (l4 == 2'h0)
        begin
            count[1] = 1'b1;
            l4 = l3[1:0];
        end
        count[0] = ~l4[1];
    end

endmodule

// ===== hw/rtl/binary32_float_adder.sv =====
// Top level of the pipelined binary32 adder with truncation.
//
// Usage: an operand word (operand_a, operand_b) enters on in_word when
// in_valid is high and in_stall is low. The sum word leaves on out_word
// when out_valid is high and out_stall is low; status tells a normal sum,
// an overflow to signed infinity, or an underflow or cancellation to zero.
// Operands are always treated as normal numbers; no special values exist.
// Stage one orders the operands by magnitude, stage two aligns and adds or
// subtracts, stage three counts leading zeros, stage four normalizes, packs
// and holds the result. Throughput is one word per cycle while the receiver
// does not stall; the stage registers set that figure.
// When the receiver stalls, a stage holding a word freezes once every stage
// below it holds a word, and in_stall rises once the pipeline is full;
// bubbles still close up under a stall, so no word is lost or repeated. Reset
// clears all valid bits, so the pipeline comes up empty; payload registers are not reset.
module binary32_float_adder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bfa_pkg::in_word_t in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output bfa_pkg::out_word_t out_word
);
    import bfa_pkg::*;

    // Stage advance: a stage loads when its downstream slot is free.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = ~v4_reg | ~out_stall;
    assign en3 = ~v3_reg | en4;
    assign en2 = ~v2_reg | en3;
    assign en1 = ~v1_reg | en2;
    assign in_stall = ~en1;

    // Stage 1: order by magnitude.
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_big;
    logic        s1_sign_next, s1_same_next;
    logic [7:0]  s1_e_next, s1_d_next;
    logic [23:0] s1_mbig_next, s1_msml_next;

    logic        s1_sign_reg, s1_same_reg;
    logic [7:0]  s1_e_reg, s1_d_reg;
    logic [23:0] s1_mbig_reg, s1_msml_reg;

    always_comb
    begin
        sa = in_word.operand_a[31];
        sb = in_word.operand_b[31];
        ea = in_word.operand_a[30:23];
        eb = in_word.operand_b[30:23];
        ma = HIDDEN_BIT | {1'b0, in_word.operand_a[22:0]};
        mb = HIDDEN_BIT | {1'b0, in_word.operand_b[22:0]};
        a_big = (ea > eb) || ((ea == eb) && (ma >= mb));
        s1_same_next = (sa == sb);
        s1_sign_next = a_big ? sa : sb;
        s1_e_next = a_big ? ea : eb;
        s1_d_next = a_big ? (ea - eb) : (eb - ea);
        s1_mbig_next = a_big ? ma : mb;
        s1_msml_next = a_big ? mb : ma;
    end

    // Stage 2: align and add or subtract.
    logic [23:0] sh;
    logic [24:0] s2_m_next;
    logic [24:0] s2_m_reg;
    logic        s2_sign_reg;
    logic [7:0]  s2_e_reg;

    always_comb
    begin
        sh = (s1_d_reg >= 8'd24) ? 24'd0 : (s1_msml_reg >> s1_d_reg[4:0]);
        if (s1_same_reg)
            s2_m_next = {1'b0, s1_mbig_reg} + {1'b0, sh};
        else
            s2_m_next = {1'b0, s1_mbig_reg} - {1'b0, sh};
    end

    // Stage 3: leading zero count.
    logic [4:0]  lz_next;
    logic [4:0]  s3_lz_reg;
    logic [24:0] s3_m_reg;
    logic        s3_sign_reg;
    logic [7:0]  s3_e_reg;

    bfa_lzc u_lzc (
        .value (s2_m_reg),
        .count (lz_next)
    );

    // Stage 4: normalize, range check, pack. lz 0 means a carry.
    logic [24:0] nm;
    logic [9:0]  ne;
    out_word_t   res_next;
    out_word_t   res_reg;

    always_comb
    begin
        nm = '0;
        ne = '0;
        res_next.sum = '0;
        res_next.status = ST_NORMAL;
        if (s3_m_reg == 25'd0)
        begin
            res_next.sum = 32'h0;
            res_next.status = ST_ZERO;
        end
        else
        begin
            if (s3_lz_reg == 5'd0)
            begin
                nm = s3_m_reg >> 1;
                ne = {2'b00, s3_e_reg} + 10'd1;
            end
            else
            begin
                nm = s3_m_reg << (s3_lz_reg - 5'd1);
                ne = {2'b00, s3_e_reg} - {5'd0, s3_lz_reg} + 10'd1;
            end
            if (!ne[9] && ne >= 10'd255)
            begin
                res_next.sum = {s3_sign_reg, 31'h7f800000};
                res_next.status = ST_OVERFLOW;
            end
            else if (ne[9] || ne == 10'd0)
            begin
                res_next.sum = {s3_sign_reg, 31'h0};
                res_next.status = ST_ZERO;
            end
            else
            begin
                res_next.sum = {s3_sign_reg, ne[7:0], nm[22:0] & FRAC_MASK};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sign_reg <= s1_sign_next;
            s1_same_reg <= s1_same_next;
            s1_e_reg <= s1_e_next;
            s1_d_reg <= s1_d_next;
            s1_mbig_reg <= s1_mbig_next;
            s1_msml_reg <= s1_msml_next;
        end
        if (en2)
        begin
            s2_m_reg <= s2_m_next;
            s2_sign_reg <= s1_sign_reg;
            s2_e_reg <= s1_e_reg;
        end
        if (en3)
        begin
            s3_lz_reg <= lz_next;
            s3_m_reg <= s2_m_reg;
            s3_sign_reg <= s2_sign_reg;
            s3_e_reg <= s2_e_reg;
        end
        if (en4)
            res_reg <= res_next;
    end

    assign out_valid = v4_reg;
    assign out_word = res_reg;

    // A held result must not change while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result changed under stall");

    // Input is refused only when every stage holds a word.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("stall with a free stage");

    // Status zero and overflow codes match the packed sum.
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status == ST_OVERFLOW |-> out_word.sum[30:0] == 31'h7f800000)
        else $error("overflow without infinity");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status == ST_ZERO |-> out_word.sum[30:0] == 31'h0)
        else $error("zero status with nonzero sum");

endmodule
